### rtl/prtt_pkg.sv
// ----------------------------------------------------------------------------
// prtt_pkg
// Shared types and constants of the retransmission task table.
// ----------------------------------------------------------------------------
package prtt_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int AGE_BITS  = 16;
    localparam int TIMER_W   = 18;
    localparam int SENDS_W   = 9;

    localparam logic [7:0] MAX_TMO_RESET = 8'd200;
    localparam logic [9:0] TPU_RESET     = 10'd100;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_SERVICE = 2'd1,
        ACT_ACK     = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        K_ADDED    = 3'd0,
        K_REJECTED = 3'd1,
        K_TRANSMIT = 3'd2,
        K_SUCCESS  = 3'd3,
        K_TIMEOUT  = 3'd4,
        K_NOTHING  = 3'd5
    } kind_t;

    typedef enum logic [0:0] {
        REG_MAX_TMO = 1'd0,
        REG_TPU     = 1'd1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEL_RD,
        ST_SEL_WR,
        ST_TO_SCAN,
        ST_ADD_WR,
        ST_DONE
    } state_t;

    // One stored task
    typedef struct packed {
        logic [7:0]          pri;
        logic [AGE_BITS-1:0] age;
        logic [15:0]         seq;
        logic [SENDS_W-1:0]  sends;
        logic [7:0]          tmo;
        logic [TIMER_W-1:0]  timer;
    } entry_t;

    // A is older than B, wrap-aware
    function automatic logic older(input logic [AGE_BITS-1:0] a,
                                   input logic [AGE_BITS-1:0] b);
        logic [AGE_BITS-1:0] ba;
        logic [AGE_BITS-1:0] ab;
        ba = b - a;
        ab = a - b;
        return ba < ab;
    endfunction

endpackage

### rtl/priority_retransmit_task_table.sv
// ----------------------------------------------------------------------------
// priority_retransmit_task_table
// Table of pending transmissions held in one synchronous memory, served by
// priority and age, with acknowledgement and timer tick passes.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall| action, priority_req, timeout_units,
//         |           |                  | resend_count, frame_seq
// out     | output    | out_valid/out_stall | kind, slot, result_seq, last
// cfg     | input     | cfg_we           | cfg_index, cfg_data
//
// Add writes the first free slot, or rejects when full, then returns to idle
// once the output is free. Tick and ack walk the memory slot by slot (read,
// then evaluate and write back), an ack ending early at its match. Service
// walks twice, with a read-modify-write of the chosen slot, if any, between;
// a zero timeout also reports success. One memory port paces the walks. Reset
// clears the valid bits, counters and control registers at once; no clearing
// pass. A result is held one deep until the next one shows whether it is
// last; the walk halts at a result while one is held and the output stalls.
// ----------------------------------------------------------------------------
module priority_retransmit_task_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  priority_req,
    input  logic [7:0]  timeout_units,
    input  logic [7:0]  resend_count,
    input  logic [15:0] frame_seq,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  slot,
    output logic [15:0] result_seq,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int SW = prtt_pkg::SLOT_W;

    // Task memory, one port, registered read
    prtt_pkg::entry_t mem [prtt_pkg::SLOTS];
    prtt_pkg::entry_t rd_data_reg;
    logic             mem_re;
    logic             mem_we;
    logic [SW-1:0]    mem_addr;
    prtt_pkg::entry_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    // Control state
    prtt_pkg::state_t     state_reg, state_next;
    logic [prtt_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [prtt_pkg::AGE_BITS-1:0] age_reg, age_next;
    logic [prtt_pkg::CNT_W-1:0] used_reg, used_next;
    logic [7:0]  max_tmo_reg;
    logic [9:0]  tpu_reg;

    // Request held for the walk
    prtt_pkg::action_t act_reg, act_next;
    logic [7:0]  pri_in_reg, pri_in_next;
    logic [7:0]  tmo_in_reg, tmo_in_next;
    logic [7:0]  rs_in_reg, rs_in_next;
    logic [15:0] seq_in_reg, seq_in_next;

    // Walk: idx is the address in flight; rd_ph says read data is present
    logic [SW-1:0] idx_reg, idx_next;
    logic          rd_ph_reg, rd_ph_next;
    logic          emitted_reg, emitted_next;

    // Service pick
    logic          sel_ok_reg, sel_ok_next;
    logic [SW-1:0] sel_reg, sel_next;
    logic [7:0]    sel_pri_reg, sel_pri_next;
    logic [prtt_pkg::AGE_BITS-1:0] sel_age_reg, sel_age_next;

    // Timer product, registered
    logic [prtt_pkg::TIMER_W-1:0] prod_reg, prod_next;

    // Result held back until it is known whether it is the last one
    logic        pend_valid_reg, pend_valid_next;
    logic [2:0]  pend_kind_reg, pend_kind_next;
    logic [3:0]  pend_slot_reg, pend_slot_next;
    logic [15:0] pend_seq_reg, pend_seq_next;
    logic        push_pend;
    logic [2:0]  new_kind;
    logic [3:0]  new_slot;
    logic [15:0] new_seq;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  slot_reg, slot_next;
    logic [15:0] rseq_reg, rseq_next;
    logic        last_reg, last_next;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign slot       = slot_reg;
    assign result_seq = rseq_reg;
    assign last       = last_reg;
    assign in_stall   = (state_reg != prtt_pkg::ST_IDLE);

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // A new result can be held when none is held or the held one can move out
    logic can_emit;
    assign can_emit = !pend_valid_reg || out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tmo_reg <= prtt_pkg::MAX_TMO_RESET;
            tpu_reg     <= prtt_pkg::TPU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (prtt_pkg::reg_index_t'(cfg_index))
                prtt_pkg::REG_MAX_TMO: max_tmo_reg <= cfg_data[7:0];
                prtt_pkg::REG_TPU:     tpu_reg     <= cfg_data;
            endcase
        end
    end

    // First free slot
    logic [SW-1:0] free_idx;
    logic          free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = prtt_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic is_last_idx;
    assign is_last_idx = (idx_reg == SW'(prtt_pkg::SLOTS - 1));

    prtt_pkg::entry_t e;
    assign e = rd_data_reg;

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        age_next        = age_reg;
        used_next       = used_reg;
        act_next        = act_reg;
        pri_in_next     = pri_in_reg;
        tmo_in_next     = tmo_in_reg;
        rs_in_next      = rs_in_reg;
        seq_in_next     = seq_in_reg;
        idx_next        = idx_reg;
        rd_ph_next      = rd_ph_reg;
        emitted_next    = emitted_reg;
        sel_ok_next     = sel_ok_reg;
        sel_next        = sel_reg;
        sel_pri_next    = sel_pri_reg;
        sel_age_next    = sel_age_reg;
        prod_next       = prod_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        pend_seq_next   = pend_seq_reg;
        push_pend       = 1'b0;
        new_kind        = prtt_pkg::K_NOTHING;
        new_slot        = '0;
        new_seq         = '0;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        rseq_next       = rseq_reg;
        last_next       = last_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = idx_reg;
        mem_wdata       = e;

        unique case (state_reg)
            prtt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = prtt_pkg::action_t'(action);
                    pri_in_next  = priority_req;
                    tmo_in_next  = timeout_units;
                    rs_in_next   = resend_count;
                    seq_in_next  = frame_seq;
                    idx_next     = '0;
                    rd_ph_next   = 1'b0;
                    emitted_next = 1'b0;
                    sel_ok_next  = 1'b0;
                    if (prtt_pkg::action_t'(action) == prtt_pkg::ACT_ADD)
                        state_next = prtt_pkg::ST_ADD_WR;
                    else
                        state_next = prtt_pkg::ST_SCAN;
                end
            end

            prtt_pkg::ST_ADD_WR:
            begin
                if (out_free)
                begin
                    age_next       = age_reg + 1'b1;
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    rseq_next      = seq_in_reg;
                    if (free_any && used_reg < prtt_pkg::CNT_W'(prtt_pkg::SLOTS))
                    begin
                        mem_we          = 1'b1;
                        mem_addr        = free_idx;
                        mem_wdata.pri   = pri_in_reg;
                        mem_wdata.age   = age_reg;
                        mem_wdata.seq   = seq_in_reg;
                        mem_wdata.sends = {1'b0, rs_in_reg} + 1'b1;
                        mem_wdata.tmo   = (tmo_in_reg > max_tmo_reg) ? max_tmo_reg
                                                                     : tmo_in_reg;
                        mem_wdata.timer = '0;
                        valid_next[free_idx] = 1'b1;
                        used_next       = used_reg + 1'b1;
                        kind_next       = prtt_pkg::K_ADDED;
                        slot_next       = 4'(free_idx);
                    end
                    else
                    begin
                        kind_next = prtt_pkg::K_REJECTED;
                        slot_next = '0;
                    end
                    state_next = prtt_pkg::ST_IDLE;
                end
            end

            // Walk the slots: read phase, then evaluate and write back
            prtt_pkg::ST_SCAN, prtt_pkg::ST_TO_SCAN:
            begin
                if (!rd_ph_reg)
                begin
                    mem_re     = 1'b1;
                    rd_ph_next = 1'b1;
                end
                else
                begin
                    logic adv;
                    adv = 1'b1;
                    if (valid_reg[idx_reg])
                    begin
                        if (state_reg == prtt_pkg::ST_TO_SCAN)
                        begin
                            if (e.sends == '0 && e.timer == '0)
                            begin
                                if (can_emit)
                                begin
                                    push_pend      = 1'b1;
                                    new_kind       = prtt_pkg::K_TIMEOUT;
                                    new_slot       = 4'(idx_reg);
                                    new_seq        = e.seq;
                                    emitted_next   = 1'b1;
                                    valid_next[idx_reg] = 1'b0;
                                    used_next      = used_reg - 1'b1;
                                end
                                else
                                    adv = 1'b0;
                            end
                        end
                        else
                        begin
                            unique case (act_reg)
                                prtt_pkg::ACT_SERVICE:
                                begin
                                    if (e.sends != '0 && e.timer == '0 &&
                                        (!sel_ok_reg || e.pri > sel_pri_reg ||
                                         (e.pri == sel_pri_reg &&
                                          prtt_pkg::older(e.age, sel_age_reg))))
                                    begin
                                        sel_ok_next  = 1'b1;
                                        sel_next     = idx_reg;
                                        sel_pri_next = e.pri;
                                        sel_age_next = e.age;
                                    end
                                end
                                prtt_pkg::ACT_ACK:
                                begin
                                    if (!emitted_reg && e.seq == seq_in_reg)
                                    begin
                                        if (can_emit)
                                        begin
                                            push_pend      = 1'b1;
                                            new_kind       = prtt_pkg::K_SUCCESS;
                                            new_slot       = 4'(idx_reg);
                                            new_seq        = seq_in_reg;
                                            emitted_next   = 1'b1;
                                            valid_next[idx_reg] = 1'b0;
                                            used_next      = used_reg - 1'b1;
                                        end
                                        else
                                            adv = 1'b0;
                                    end
                                end
                                prtt_pkg::ACT_TICK:
                                begin
                                    if (e.timer != '0)
                                    begin
                                        mem_we          = 1'b1;
                                        mem_wdata.timer = e.timer - 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    if (adv)
                    begin
                        rd_ph_next = 1'b0;
                        idx_next   = idx_reg + 1'b1;
                        if (is_last_idx || (act_reg == prtt_pkg::ACT_ACK &&
                                            emitted_next))
                        begin
                            idx_next = '0;
                            if (state_reg == prtt_pkg::ST_SCAN &&
                                act_reg == prtt_pkg::ACT_SERVICE)
                                state_next = sel_ok_next ? prtt_pkg::ST_SEL_RD
                                                         : prtt_pkg::ST_TO_SCAN;
                            else
                                state_next = prtt_pkg::ST_DONE;
                        end
                    end
                end
            end

            // Read the chosen slot and form the timer product
            prtt_pkg::ST_SEL_RD:
            begin
                mem_addr = sel_reg;
                if (!rd_ph_reg)
                begin
                    mem_re     = 1'b1;
                    rd_ph_next = 1'b1;
                end
                else
                begin
                    prod_next  = prtt_pkg::TIMER_W'(e.tmo * tpu_reg);
                    rd_ph_next = 1'b0;
                    state_next = prtt_pkg::ST_SEL_WR;
                end
            end

            // Report transmit (and success on zero timeout), write back
            prtt_pkg::ST_SEL_WR:
            begin
                mem_addr = sel_reg;
                if (can_emit)
                begin
                    if (!rd_ph_reg)
                    begin
                        push_pend       = 1'b1;
                        new_kind        = prtt_pkg::K_TRANSMIT;
                        new_slot        = 4'(sel_reg);
                        new_seq         = e.seq;
                        emitted_next    = 1'b1;
                        mem_we          = 1'b1;
                        mem_wdata.sends = e.sends - 1'b1;
                        mem_wdata.timer = prod_reg;
                        if (e.tmo == '0)
                            rd_ph_next = 1'b1;
                        else
                            state_next = prtt_pkg::ST_TO_SCAN;
                    end
                    else
                    begin
                        push_pend      = 1'b1;
                        new_kind       = prtt_pkg::K_SUCCESS;
                        new_slot       = 4'(sel_reg);
                        new_seq        = e.seq;
                        valid_next[sel_reg] = 1'b0;
                        used_next      = used_reg - 1'b1;
                        rd_ph_next     = 1'b0;
                        state_next     = prtt_pkg::ST_TO_SCAN;
                    end
                end
            end

            // Close: send the held result as last, or a nothing result
            prtt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (pend_valid_reg)
                    begin
                        kind_next = pend_kind_reg;
                        slot_next = pend_slot_reg;
                        rseq_next = pend_seq_reg;
                    end
                    else
                    begin
                        kind_next = prtt_pkg::K_NOTHING;
                        slot_next = '0;
                        rseq_next = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = prtt_pkg::ST_IDLE;
                end
            end

            default: state_next = prtt_pkg::ST_IDLE;
        endcase

        // Move the held result out as not last, and hold the new one
        if (push_pend)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = pend_kind_reg;
                slot_next      = pend_slot_reg;
                rseq_next      = pend_seq_reg;
                last_next      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = new_kind;
            pend_slot_next  = new_slot;
            pend_seq_next   = new_seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prtt_pkg::ST_IDLE;
            valid_reg      <= '0;
            age_reg        <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            rd_ph_reg      <= 1'b0;
            emitted_reg    <= 1'b0;
            sel_ok_reg     <= 1'b0;
            idx_reg        <= '0;
            act_reg        <= prtt_pkg::ACT_ADD;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            age_reg        <= age_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            rd_ph_reg      <= rd_ph_next;
            emitted_reg    <= emitted_next;
            sel_ok_reg     <= sel_ok_next;
            idx_reg        <= idx_next;
            act_reg        <= act_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pri_in_reg    <= pri_in_next;
        tmo_in_reg    <= tmo_in_next;
        rs_in_reg     <= rs_in_next;
        seq_in_reg    <= seq_in_next;
        sel_reg       <= sel_next;
        sel_pri_reg   <= sel_pri_next;
        sel_age_reg   <= sel_age_next;
        prod_reg      <= prod_next;
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        pend_seq_reg  <= pend_seq_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        rseq_reg      <= rseq_next;
        last_reg      <= last_next;
    end

    // Assertions
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == prtt_pkg::CNT_W'($countones(valid_reg)))
        else $error("used count differs from valid bits");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != prtt_pkg::ST_IDLE) |-> in_stall)
        else $error("request taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable({kind, slot, result_seq, last})))
        else $error("stalled result changed");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prtt_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind");

endmodule
